// ===== rtl/mul_div_mac_register_unit_core_macros.svh =====
`ifndef MUL_DIV_MAC_REGISTER_UNIT_CORE_MACROS_SVH
`define MUL_DIV_MAC_REGISTER_UNIT_CORE_MACROS_SVH

// implication in the same cycle
`define MDMAC_AIMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdmac check failed");

// implication in the next cycle
`define MDMAC_ANXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdmac check failed");

`endif

// ===== rtl/mdmac_pkg.sv =====
package mdmac_pkg;

  localparam int OFF_W  = 3;
  localparam int BYTE_W = 8;
  localparam int OPND_W = 16;
  localparam int WORD_W = 32;
  localparam int ACC_W  = 64;
  localparam int MODE_W = 2;
  localparam int CNT_W  = 4;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [OFF_W-1:0] REG_CTRL   = 3'd0;
  localparam logic [OFF_W-1:0] REG_OPA_LO = 3'd1;
  localparam logic [OFF_W-1:0] REG_OPA_HI = 3'd2;
  localparam logic [OFF_W-1:0] REG_OPB_LO = 3'd3;
  localparam logic [OFF_W-1:0] REG_OPB_HI = 3'd4;
  localparam logic [OFF_W-1:0] RD_MAX     = 3'd4;

  localparam logic [MODE_W-1:0] MODE_MUL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DIV = 2'd1;

  localparam int CTRL_CLR_BIT = 1;
  localparam int OVF_LO       = 32;
  localparam int OVF_HI       = 55;

  localparam logic [CNT_W-1:0] CNT_LAST = 4'd15;

endpackage

// ===== rtl/mdmac_if.sv =====
interface mdmac_in_if import mdmac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [OFF_W-1:0]  reg_offset;
  logic [BYTE_W-1:0] wdata;

  modport source (output valid, operation, reg_offset, wdata, input ready);
  modport sink (input valid, operation, reg_offset, wdata, output ready);
endinterface

interface mdmac_out_if import mdmac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rdata;
  logic              overflow_flag;

  modport source (output valid, rdata, overflow_flag, input ready);
  modport sink (input valid, rdata, overflow_flag, output ready);
endinterface

// ===== rtl/mul_div_mac_register_unit_core.sv =====
// reads and register writes that start nothing: result registered in the cycle after the beat
// operand_b high byte write: 16 iterations of one shared 32-bit add/subtract unit
// (shift-add multiply, also for multiply-accumulate, or restoring divide), then the S_DONE finish state
// divide by zero starts nothing and clears the accumulator; no new beat is taken while an operation runs
// synchronous active-low reset clears operands, mode, accumulator and overflow flag
module mul_div_mac_register_unit_core import mdmac_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mdmac_in_if.sink          in_ch,
  mdmac_out_if.source       out_ch
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OPND_W-1:0] opa_r, opa_nxt;
  logic [OPND_W-1:0] opb_r, opb_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [WORD_W-1:0] work_r, work_nxt;
  logic [WORD_W-1:0] mcand_r, mcand_nxt;
  logic [OPND_W-1:0] mplier_r, mplier_nxt;
  logic              aneg_r, aneg_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_rdata_r, out_rdata_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              in_fire;
  logic              div_mode;
  logic [WORD_W-1:0] add_a, add_b, add_sum;
  logic              add_sub;
  logic [ACC_W-1:0]  acc_shift;
  logic [BYTE_W-1:0] rd_byte;
  logic [OPND_W-1:0] opb_new;
  logic [ACC_W-1:0]  prod_ext, mac_sum;
  logic [OPND_W-1:0] q16, r16;
  logic              q_neg;
  logic [WORD_W-1:0] div_word;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.rdata         = out_rdata_r;
  assign out_ch.overflow_flag = out_ovf_r;

  // shared add/subtract unit
  assign div_mode = (mode_r == MODE_DIV);
  assign add_a    = div_mode ? {15'd0, work_r[OPND_W-1:0], mplier_r[OPND_W-1]} : work_r;
  assign add_sub  = div_mode || (cnt_r == CNT_LAST);
  assign add_b    = add_sub ? ~mcand_r : mcand_r;
  assign add_sum  = add_a + add_b + {31'd0, add_sub};

  assign acc_shift = acc_r >> {in_ch.reg_offset, 3'b000};
  assign rd_byte   = (in_ch.reg_offset <= RD_MAX) ? acc_shift[BYTE_W-1:0] : '0;
  assign opb_new   = {in_ch.wdata, opb_r[BYTE_W-1:0]};

  assign prod_ext = {{WORD_W{work_r[WORD_W-1]}}, work_r};
  assign mac_sum  = acc_r + prod_ext;

  // sign fix of quotient and remainder
  assign q16      = aneg_r ? (~mplier_r + 16'd1) : mplier_r;
  assign r16      = aneg_r ? (~work_r[OPND_W-1:0] + 16'd1) : work_r[OPND_W-1:0];
  assign q_neg    = aneg_r && (mplier_r != '0);
  assign div_word = {({OPND_W{q_neg}} | r16), q16};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    mode_nxt      = mode_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    work_nxt      = work_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    aneg_nxt      = aneg_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rdata_nxt = out_rdata_r;
    out_ovf_nxt   = out_ovf_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          out_rdata_nxt = '0;
          out_ovf_nxt   = ovf_r;
          if (in_ch.operation == OP_READ) begin
            out_rdata_nxt = rd_byte;
          end else begin
            case (in_ch.reg_offset)
              REG_CTRL: begin
                mode_nxt = in_ch.wdata[MODE_W-1:0];
                if (in_ch.wdata[CTRL_CLR_BIT]) begin
                  acc_nxt = '0;
                end
              end
              REG_OPA_LO: opa_nxt = {opa_r[OPND_W-1:BYTE_W], in_ch.wdata};
              REG_OPA_HI: opa_nxt = {in_ch.wdata, opa_r[BYTE_W-1:0]};
              REG_OPB_LO: opb_nxt = {opb_r[OPND_W-1:BYTE_W], in_ch.wdata};
              REG_OPB_HI: begin
                opb_nxt = opb_new;
                if (div_mode && (opb_new == '0)) begin
                  acc_nxt = '0;
                end else begin
                  out_valid_nxt = 1'b0;
                  state_nxt     = S_RUN;
                  cnt_nxt       = '0;
                  work_nxt      = '0;
                  if (div_mode) begin
                    mcand_nxt  = {16'd0, opb_new};
                    mplier_nxt = opa_r[OPND_W-1] ? (~opa_r + 16'd1) : opa_r;
                    aneg_nxt   = opa_r[OPND_W-1];
                  end else begin
                    mcand_nxt  = {{OPND_W{opa_r[OPND_W-1]}}, opa_r};
                    mplier_nxt = opb_new;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_DONE;
        end
        if (div_mode) begin
          if (add_sum[WORD_W-1]) begin
            work_nxt   = add_a;
            mplier_nxt = {mplier_r[OPND_W-2:0], 1'b0};
          end else begin
            work_nxt   = add_sum;
            mplier_nxt = {mplier_r[OPND_W-2:0], 1'b1};
          end
        end else begin
          if (mplier_r[0]) begin
            work_nxt = add_sum;
          end
          mplier_nxt = {1'b0, mplier_r[OPND_W-1:1]};
          mcand_nxt  = {mcand_r[WORD_W-2:0], 1'b0};
        end
      end
      S_DONE: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        out_rdata_nxt = '0;
        out_ovf_nxt   = ovf_r;
        if (mode_r == MODE_MUL) begin
          acc_nxt = prod_ext;
        end else if (div_mode) begin
          acc_nxt = {{WORD_W{div_word[WORD_W-1]}}, div_word};
        end else begin
          acc_nxt = mac_sum;
          if (mac_sum[OVF_HI:OVF_LO] != '0) begin
            ovf_nxt     = 1'b1;
            out_ovf_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      opa_r       <= '0;
      opb_r       <= '0;
      mode_r      <= MODE_MUL;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      opa_r       <= opa_nxt;
      opb_r       <= opb_nxt;
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    aneg_r      <= aneg_nxt;
    out_rdata_r <= out_rdata_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

// ===== rtl/mdmac_checker.sv =====
`include "mul_div_mac_register_unit_core_macros.svh"

module mdmac_checker import mdmac_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_rdata,
  input logic              out_overflow_flag
);

  logic seen_r;

  // overflow once shown on a beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready && out_overflow_flag) begin
      seen_r <= 1'b1;
    end
  end

  `MDMAC_ANXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_rdata))
  `MDMAC_AIMP(a_ovf_sticky, out_valid && seen_r, out_overflow_flag)
  `MDMAC_AIMP(a_no_overrun, in_valid && in_ready, !out_valid || out_ready)

endmodule

bind mul_div_mac_register_unit_core mdmac_checker u_mdmac_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_rdata         (out_ch.rdata),
  .out_overflow_flag (out_ch.overflow_flag)
);
